/* sv/eqi_pkg.sv */
// Shared types, codes and helpers of the element quadrature integral block.
// Used by the controller, the datapath, the multiplier and the top level.
package eqi_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD_MATRIX = 2'd0,
		ACT_LOAD_WEIGHT = 2'd1,
		ACT_NODE        = 2'd2,
		ACT_NONE        = 2'd3
	} eqi_action_t;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_VAL_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_PER_ELEMENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QUADRATURE_POINTS  = 1'b1;

	localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         row_index;
		logic [3:0]         column_index;
		logic signed [31:0] table_value;
		logic signed [31:0] node_value;
		logic signed [31:0] jacobian_value;
		logic               last_element;
	} eqi_in_t;

	typedef struct packed {
		logic signed [63:0] integral_value;
		logic               batch_end;
		logic               saturated;
	} eqi_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} eqi_cfg_t;

	typedef struct packed {
		logic cap_node;
		logic wr_mat;
		logic wr_wt;
		logic acc_rd;
		logic mul_f;
		logic wr_val;
		logic wr_jac;
		logic fin_rd;
		logic mul_start;
		logic mul_sel_w;
		logic take_t;
		logic add_sum;
		logic clr_sum;
		logic load_out;
		logic clr_elem;
	} eqi_cmd_t;

	typedef struct packed {
		logic mul_done;
	} eqi_status_t;

	typedef struct packed {
		logic               ovf;
		logic signed [63:0] sum;
	} eqi_sum_t;

	function automatic eqi_sum_t sat_add64(logic signed [63:0] a, logic signed [63:0] b);
		eqi_sum_t   r;
		logic [63:0] s;
		s = a + b;
		r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
		r.sum = r.ovf ? (a[63] ? SAT_MIN : SAT_MAX) : s;
		return r;
	endfunction

endpackage

/* sv/eqi_chan_if.sv */
// Valid/ready channel carrying one payload item per handshake.
// Payload type is set at instantiation; no package dependency.
interface eqi_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/element_quadrature_integral.sv */
// Element integral by Gauss quadrature. Load items (matrix entry, weight) are written from idle.
// For a node item, per quadrature point there is one matrix-entry read and two
// 32x32 products through the single accumulate multiplier. The node that closes an element
// adds per point two 64-bit products on the shared four-pass multiplier.
// The result waits in an output register; new items are taken while it waits.
// Tables are undefined until loaded; accumulators clear per element without a sweep.
module element_quadrature_integral import eqi_pkg::*; #(
	parameter int MAX_NODES       = 16,
	parameter int MAX_QUAD_POINTS = 16
) (
	input logic        clk,
	input logic        arst_n,
	eqi_chan_if.sink   in_item,
	eqi_chan_if.source out_item,
	eqi_chan_if.sink   cfg_write
);

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int QW = (MAX_QUAD_POINTS > 1) ? $clog2(MAX_QUAD_POINTS) : 1;

	eqi_cmd_t      cmd;
	eqi_status_t   status;
	logic [QW-1:0] q_idx;
	logic [NW-1:0] node_idx;
	eqi_in_t       in_data;
	eqi_cfg_t      cfg_data;
	eqi_out_t      out_data;

	assign in_data       = in_item.data;
	assign cfg_data      = cfg_write.data;
	assign out_item.data = out_data;

	eqi_ctrl #(
		.MAX_NODES       (MAX_NODES),
		.MAX_QUAD_POINTS (MAX_QUAD_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_item.valid),
		.in_action (in_data.action),
		.in_ready  (in_item.ready),
		.cfg_valid (cfg_write.valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_write.ready),
		.out_valid (out_item.valid),
		.out_ready (out_item.ready),
		.cmd       (cmd),
		.status    (status),
		.q_idx     (q_idx),
		.node_idx  (node_idx)
	);

	eqi_datapath #(
		.MAX_NODES       (MAX_NODES),
		.MAX_QUAD_POINTS (MAX_QUAD_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_idx    (q_idx),
		.node_idx (node_idx),
		.in_data  (in_data),
		.out_data (out_data),
		.status   (status)
	);

endmodule

/* sv/eqi_mul64.sv */
// Signed 64x64 multiply with floor shift (30 or 32) and clip to 64 bits.
// Four passes of one 32x32 multiplier; depends on eqi_pkg.
module eqi_mul64 import eqi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               sh30,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic [63:0]        res,
	output logic               clip,
	output logic               done
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b000_0001,
		ST_PP0  = 7'b000_0010,
		ST_PP1  = 7'b000_0100,
		ST_PP2  = 7'b000_1000,
		ST_PP3  = 7'b001_0000,
		ST_NEG  = 7'b010_0000,
		ST_OUT  = 7'b100_0000
	} mul_state_t;

	mul_state_t   step_q;
	logic         done_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q, sh30_q;
	logic [127:0] acc_q;
	logic [63:0]  res_q;
	logic         clip_q;

	logic [31:0]  pp_a, pp_b;
	logic [63:0]  pp;
	logic [127:0] addend;
	logic signed [127:0] rs;
	logic         fits;

	always_comb begin
		pp_a = ma_q[31:0];
		pp_b = mb_q[31:0];
		unique case (step_q)
			ST_PP1: pp_b = mb_q[63:32];
			ST_PP2: pp_a = ma_q[63:32];
			ST_PP3: begin
				pp_a = ma_q[63:32];
				pp_b = mb_q[63:32];
			end
			default: ;
		endcase
		pp = pp_a * pp_b;
		unique case (step_q)
			ST_PP0:         addend = {64'b0, pp};
			ST_PP1, ST_PP2: addend = {32'b0, pp, 32'b0};
			ST_PP3:         addend = {pp, 64'b0};
			default:        addend = '0;
		endcase
		rs = sh30_q ? ($signed(acc_q) >>> 30) : ($signed(acc_q) >>> 32);
		fits = (&rs[127:63]) | ~(|rs[127:63]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (step_q)
				ST_IDLE: if (start) step_q <= ST_PP0;
				ST_PP0:  step_q <= ST_PP1;
				ST_PP1:  step_q <= ST_PP2;
				ST_PP2:  step_q <= ST_PP3;
				ST_PP3:  step_q <= ST_NEG;
				ST_NEG:  step_q <= ST_OUT;
				ST_OUT: begin
					done_q <= 1'b1;
					step_q <= ST_IDLE;
				end
				default: step_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == ST_IDLE && start) begin
			ma_q   <= a[63] ? 64'(-a) : a;
			mb_q   <= b[63] ? 64'(-b) : b;
			neg_q  <= a[63] ^ b[63];
			sh30_q <= sh30;
			acc_q  <= '0;
		end else if (step_q == ST_NEG) begin
			acc_q <= neg_q ? (~acc_q + 128'd1) : acc_q;
		end else if (step_q == ST_OUT) begin
			res_q  <= fits ? rs[63:0] : (rs[127] ? SAT_MIN : SAT_MAX);
			clip_q <= ~fits;
		end else if (step_q != ST_IDLE) begin
			acc_q <= acc_q + addend;
		end
	end

	assign res  = res_q;
	assign clip = clip_q;
	assign done = done_q;

endmodule

/* sv/eqi_datapath.sv */
// Datapath: matrix, weight and accumulator stores, the accumulate MAC,
// the final-sum path and the output register. Depends on eqi_pkg, eqi_mul64.
module eqi_datapath import eqi_pkg::*; #(
	parameter int MAX_NODES       = 16,
	parameter int MAX_QUAD_POINTS = 16,
	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
	localparam int QW = (MAX_QUAD_POINTS > 1) ? $clog2(MAX_QUAD_POINTS) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  eqi_cmd_t    cmd,
	input  logic [QW-1:0] q_idx,
	input  logic [NW-1:0] node_idx,
	input  eqi_in_t     in_data,
	output eqi_out_t    out_data,
	output eqi_status_t status
);

	localparam int DEPTH = MAX_QUAD_POINTS * MAX_NODES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0] mat_mem [DEPTH];
	logic [31:0] wt_mem  [MAX_QUAD_POINTS];
	logic [63:0] val_mem [MAX_QUAD_POINTS];
	logic [63:0] jac_mem [MAX_QUAD_POINTS];
	logic [MAX_QUAD_POINTS-1:0] acc_vld_q;

	logic signed [31:0] mat_rd_q, w_rd_q, f_q, j_q;
	logic signed [63:0] val_rd_q, jac_rd_q, prod_q, t_q, sum_q;
	logic               vld_rd_q, last_q, sat_q;
	eqi_out_t           out_q;

	logic [AW-1:0]      wr_addr, rd_addr;
	logic               row_ok, col_ok;
	logic signed [63:0] val_eff, jac_eff, inc, mul_a, mul_b;
	logic signed [31:0] mop;
	eqi_sum_t           add_val, add_jac, add_sum;
	logic [63:0]        mul_res;
	logic               mul_clip, mul_done;

	assign row_ok  = int'(in_data.row_index) < MAX_QUAD_POINTS;
	assign col_ok  = int'(in_data.column_index) < MAX_NODES;
	assign wr_addr = AW'(AW'(in_data.row_index) * AW'(MAX_NODES) + AW'(in_data.column_index));
	assign rd_addr = AW'(AW'(q_idx) * AW'(MAX_NODES) + AW'(node_idx));

	// entries not yet written in this element read as zero
	assign val_eff = vld_rd_q ? val_rd_q : 64'sd0;
	assign jac_eff = vld_rd_q ? jac_rd_q : 64'sd0;
	assign inc     = prod_q >>> 14;
	assign add_val = sat_add64(val_eff, inc);
	assign add_jac = sat_add64(jac_eff, inc);
	assign add_sum = sat_add64(sum_q, $signed(mul_res));
	assign mop     = cmd.wr_val ? j_q : f_q;
	assign mul_a   = cmd.mul_sel_w ? 64'(w_rd_q) : jac_eff;
	assign mul_b   = cmd.mul_sel_w ? t_q : val_eff;

	eqi_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.sh30   (cmd.mul_sel_w),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.clip   (mul_clip),
		.done   (mul_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.wr_mat && row_ok && col_ok) mat_mem[wr_addr] <= in_data.table_value;
		if (cmd.acc_rd) mat_rd_q <= mat_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_wt && row_ok) wt_mem[QW'(in_data.row_index)] <= in_data.table_value;
		if (cmd.fin_rd) w_rd_q <= wt_mem[q_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_val) val_mem[q_idx] <= add_val.sum;
		if (cmd.wr_jac) jac_mem[q_idx] <= add_jac.sum;
		if (cmd.acc_rd || cmd.fin_rd) begin
			val_rd_q <= val_mem[q_idx];
			jac_rd_q <= jac_mem[q_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			vld_rd_q  <= 1'b0;
			sat_q     <= 1'b0;
		end else begin
			if (cmd.acc_rd || cmd.fin_rd) vld_rd_q <= acc_vld_q[q_idx];
			if (cmd.clr_elem) begin
				acc_vld_q <= '0;
				sat_q     <= 1'b0;
			end else begin
				if (cmd.wr_jac) acc_vld_q[q_idx] <= 1'b1;
				if ((cmd.wr_val && add_val.ovf) || (cmd.wr_jac && add_jac.ovf) ||
				    (cmd.take_t && mul_clip) ||
				    (cmd.add_sum && (mul_clip || add_sum.ovf)))
					sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_node) begin
			f_q    <= in_data.node_value;
			j_q    <= in_data.jacobian_value;
			last_q <= in_data.last_element;
		end
		if (cmd.mul_f || cmd.wr_val) prod_q <= mat_rd_q * mop;
		if (cmd.take_t) t_q <= $signed(mul_res);
		if (cmd.clr_sum) sum_q <= 64'sd0;
		else if (cmd.add_sum) sum_q <= add_sum.sum;
		if (cmd.load_out) begin
			out_q.integral_value <= sum_q;
			out_q.batch_end      <= last_q;
			out_q.saturated      <= sat_q;
		end
	end

	assign out_data        = out_q;
	assign status.mul_done = mul_done;

endmodule

/* sv/eqi_ctrl.sv */
// Controller: configuration registers, point and node counters, the
// sequencing state machine and the output valid flag. Depends on eqi_pkg.
module eqi_ctrl import eqi_pkg::*; #(
	parameter int MAX_NODES       = 16,
	parameter int MAX_QUAD_POINTS = 16,
	localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
	localparam int QW  = (MAX_QUAD_POINTS > 1) ? $clog2(MAX_QUAD_POINTS) : 1,
	localparam int NCW = $clog2(MAX_NODES + 1),
	localparam int QCW = $clog2(MAX_QUAD_POINTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_action,
	output logic          in_ready,
	input  logic          cfg_valid,
	input  eqi_cfg_t      cfg_data,
	output logic          cfg_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output eqi_cmd_t      cmd,
	input  eqi_status_t   status,
	output logic [QW-1:0] q_idx,
	output logic [NW-1:0] node_idx
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_A_RD = 11'b000_0000_0010,
		S_A_MF = 11'b000_0000_0100,
		S_A_MJ = 11'b000_0000_1000,
		S_A_WJ = 11'b000_0001_0000,
		S_F_RD = 11'b000_0010_0000,
		S_F_M1 = 11'b000_0100_0000,
		S_F_W1 = 11'b000_1000_0000,
		S_F_M2 = 11'b001_0000_0000,
		S_F_W2 = 11'b010_0000_0000,
		S_F_OUT = 11'b100_0000_0000
	} eqi_state_t;

	eqi_state_t     state_q, state_d;
	logic [QCW-1:0] q_q, q_nxt, nq;
	logic [NCW-1:0] node_q, node_nxt, np;
	logic [CFG_VAL_W-1:0] ppe_q, nqp_q;
	logic           out_valid_q;
	logic           accept, q_last, out_free;

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (ppe_q == '0) np = NCW'(1);
		else if (int'(ppe_q) > MAX_NODES) np = NCW'(MAX_NODES);
		else np = NCW'(ppe_q);
		if (nqp_q == '0) nq = QCW'(1);
		else if (int'(nqp_q) > MAX_QUAD_POINTS) nq = QCW'(MAX_QUAD_POINTS);
		else nq = QCW'(nqp_q);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign q_nxt     = q_q + 1'b1;
	assign q_last    = (q_nxt == nq);
	assign node_nxt  = node_q + 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign q_idx     = q_q[QW-1:0];
	assign node_idx  = node_q[NW-1:0];
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_action)
						ACT_LOAD_MATRIX: cmd.wr_mat = 1'b1;
						ACT_LOAD_WEIGHT: cmd.wr_wt = 1'b1;
						ACT_NODE: begin
							cmd.cap_node = 1'b1;
							state_d      = S_A_RD;
						end
						default: ;
					endcase
				end
			end
			S_A_RD: begin
				cmd.acc_rd = 1'b1;
				state_d    = S_A_MF;
			end
			S_A_MF: begin
				cmd.mul_f = 1'b1;
				state_d   = S_A_MJ;
			end
			S_A_MJ: begin
				cmd.wr_val = 1'b1;
				state_d    = S_A_WJ;
			end
			S_A_WJ: begin
				cmd.wr_jac = 1'b1;
				if (!q_last) state_d = S_A_RD;
				else if (node_nxt >= np) begin
					cmd.clr_sum = 1'b1;
					state_d     = S_F_RD;
				end else state_d = S_IDLE;
			end
			S_F_RD: begin
				cmd.fin_rd = 1'b1;
				state_d    = S_F_M1;
			end
			S_F_M1: begin
				cmd.mul_start = 1'b1;
				state_d       = S_F_W1;
			end
			S_F_W1: begin
				if (status.mul_done) begin
					cmd.take_t = 1'b1;
					state_d    = S_F_M2;
				end
			end
			S_F_M2: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel_w = 1'b1;
				state_d       = S_F_W2;
			end
			S_F_W2: begin
				cmd.mul_sel_w = 1'b1;
				if (status.mul_done) begin
					cmd.add_sum = 1'b1;
					state_d     = q_last ? S_F_OUT : S_F_RD;
				end
			end
			S_F_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.clr_elem = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			q_q         <= '0;
			node_q      <= '0;
			ppe_q       <= CFG_VAL_W'(1);
			nqp_q       <= CFG_VAL_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.cap_node) q_q <= '0;
			else if (cmd.wr_jac) q_q <= q_last ? '0 : q_nxt;
			else if (cmd.add_sum) q_q <= q_last ? '0 : q_nxt;
			if (cmd.wr_jac && q_last) node_q <= (node_nxt >= np) ? '0 : node_nxt;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_data.index)
					REG_POINTS_PER_ELEMENT: ppe_q <= cfg_data.value;
					REG_QUADRATURE_POINTS:  nqp_q <= cfg_data.value;
					default: ;
				endcase
			end
		end
	end

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> (state_q == S_F_W1 || state_q == S_F_W2))
		else $error("multiplier finished outside a wait state");

	a_point_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_F_OUT) |-> (q_q < nq))
		else $error("quadrature point counter beyond point count");

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_F_OUT)
		else $error("result raised outside the output state");

endmodule
